// ===== src/p2s_pkg.sv =====
// shared types and constants for the point to screen projection block
// used by p2s_div and point_to_screen_projection; depends on nothing
package p2s_pkg;

	// field widths of the stream items
	localparam int COEF_W      = 32;
	localparam int IDX_W       = 5;
	localparam int POS_W       = 32;
	localparam int OUT_W       = 32;
	localparam int IN_DATA_W   = 136;
	localparam int OUT_DATA_W  = 96;
	localparam int NUM_COEF    = 32;

	// configuration port
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int VP_POS_W    = 12;
	localparam int VP_SIZE_W   = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_VP_X      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VP_Y      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VP_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VP_HEIGHT = 2'd3;

	localparam logic [VP_SIZE_W-1:0] VP_WIDTH_RST  = 13'd640;
	localparam logic [VP_SIZE_W-1:0] VP_HEIGHT_RST = 13'd480;

	// item kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_PROJECT = 1'b1;

	// clamp limits of products and of the divide result
	localparam int PROD_LIM_SHIFT = 60;
	localparam int PROD_W         = 62;
	localparam int NDC_LIM_SHIFT  = 48;
	localparam int NDC_MAG_W      = 49;
	localparam int NDC_W          = 50;

	// status of the divider pipeline as seen by the top level
	typedef struct packed {
		logic valid;
		logic zero;
		logic busy;
	} div_stat_t;

endpackage

// ===== src/p2s_div.sv =====
// pipelined restoring divider for three lanes, one quotient bit per stage
// computes ndc = clip * 2^frac / (-eye_z), rounded and clamped; uses p2s_pkg
module p2s_div #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [COORD_WIDTH-1:0]          num [3],
	input  logic signed [COORD_WIDTH-1:0]          eye_z,
	output logic signed [p2s_pkg::NDC_W-1:0]       ndc [3],
	output p2s_pkg::div_stat_t                     stat
);

	localparam int CW = COORD_WIDTH;
	localparam int NB = COORD_WIDTH + FRAC_BITS;
	localparam int QW = (NB + 1 > p2s_pkg::NDC_MAG_W) ? NB + 1 : p2s_pkg::NDC_MAG_W;
	localparam logic [QW-1:0] QLIM = QW'(1) << p2s_pkg::NDC_LIM_SHIFT;

	logic [NB+1:0]   v_s;
	logic            zero_s [0:NB];
	logic [2:0]      neg_s  [0:NB];
	logic [CW-1:0]   den_s  [0:NB];
	logic [CW-1:0]   rem_s  [0:NB][3];
	logic [NB-1:0]   num_s  [0:NB][3];
	logic [NB-1:0]   quo_s  [0:NB][3];
	logic            zero_out_s;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NB:0], in_valid};
		end
	end

	// prep stage: magnitudes, signs, numerator scaled by the fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (eye_z == '0);
			den_s[0]  <= eye_z[CW-1] ? CW'(-eye_z) : CW'(eye_z);
			for (int j = 0; j < 3; j++) begin
				neg_s[0][j]  <= num[j][CW-1] ^ (!eye_z[CW-1] && (eye_z != '0));
				num_s[0][j]  <= (num[j][CW-1] ? NB'($unsigned(CW'(-num[j])))
				                              : NB'($unsigned(CW'(num[j]))))
				                << FRAC_BITS;
				rem_s[0][j]  <= '0;
				quo_s[0][j]  <= '0;
			end
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= NB; k++) begin : g_bit
		always_ff @(posedge clk) begin
			logic [CW:0] trial;
			if (en) begin
				zero_s[k] <= zero_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				den_s[k]  <= den_s[k-1];
				for (int j = 0; j < 3; j++) begin
					trial = {rem_s[k-1][j], num_s[k-1][j][NB-1]};
					num_s[k][j] <= num_s[k-1][j] << 1;
					if (trial >= {1'b0, den_s[k-1]}) begin
						rem_s[k][j] <= CW'(trial - {1'b0, den_s[k-1]});
						quo_s[k][j] <= {quo_s[k-1][j][NB-2:0], 1'b1};
					end else begin
						rem_s[k][j] <= CW'(trial);
						quo_s[k][j] <= {quo_s[k-1][j][NB-2:0], 1'b0};
					end
				end
			end
		end
	end

	// round half away from zero, clamp, restore the sign
	always_ff @(posedge clk) begin
		logic [QW-1:0] q1;
		logic          up;
		if (en) begin
			zero_out_s <= zero_s[NB];
			for (int j = 0; j < 3; j++) begin
				up = ({1'b0, rem_s[NB][j]} << 1) >= {1'b0, den_s[NB]};
				q1 = QW'(quo_s[NB][j]) + QW'(up);
				if (q1 > QLIM)
					q1 = QLIM;
				ndc[j] <= neg_s[NB][j]
				          ? -$signed({1'b0, q1[p2s_pkg::NDC_MAG_W-1:0]})
				          : $signed({1'b0, q1[p2s_pkg::NDC_MAG_W-1:0]});
			end
		end
	end

	assign stat.valid = v_s[NB+1];
	assign stat.zero  = zero_out_s;
	assign stat.busy  = |v_s;

endmodule

// ===== src/point_to_screen_projection.sv =====
// Point to window projection. Load requests (tuser 0) write one Q16.16 coefficient of the
// modelview (0-15) or projection (16-31) matrix; project requests (tuser 1) return one
// window point per request. The pipeline takes one project request per clock unless the skid
// stage holds a result; a result passes stages 1 to 4, the divider, which resolves one
// quotient bit per stage, stage 5 and the output register. A load request waits until no
// project request is in flight.
// Load every coefficient before projecting.
// depends on p2s_pkg and p2s_div
module point_to_screen_projection #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [p2s_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [p2s_pkg::CFG_DATA_W-1:0]        cfg_data,
	// requests
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// coef_index, coef_value, pos_x, pos_y, pos_z, zero fill
	input  logic [p2s_pkg::IN_DATA_W-1:0]         s_axis_tdata,
	// kind
	input  logic                                  s_axis_tuser,
	// results
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// screen_x, screen_y, screen_depth
	output logic [p2s_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// point_valid
	output logic                                  m_axis_tuser
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = ((CW > 32) ? CW : 32) + 32;
	localparam int MW  = (PW > 61) ? PW : 61;
	localparam int TW  = p2s_pkg::PROD_W;
	localparam int NW  = p2s_pkg::NDC_W;
	localparam int VW  = NW + 1 + p2s_pkg::VP_SIZE_W + 1;
	localparam int FW  = VW + 2;
	localparam logic [MW-1:0]        PLIM = MW'(1) << p2s_pkg::PROD_LIM_SHIFT;
	localparam logic signed [63:0]   CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam logic signed [63:0]   CMIN = -(64'sd1 <<< (CW - 1));
	localparam logic signed [FW-1:0] OMAX = (FW'(1) <<< 31) - FW'(1);
	localparam logic signed [FW-1:0] OMIN = -(FW'(1) <<< 31);

	// product to FRAC_BITS fraction bits, half away from zero, clamped
	function automatic logic signed [TW-1:0] rnd(input logic signed [PW-1:0] p);
		logic [MW-1:0] m;
		logic [MW-1:0] r;
		m = p[PW-1] ? MW'(-p) : MW'(p);
		r = (m + (MW'(1) << (F - 1))) >> F;
		if (r > PLIM)
			r = PLIM;
		return p[PW-1] ? -$signed(TW'(r)) : $signed(TW'(r));
	endfunction

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [63:0] s);
		if (s > CMAX)
			return CMAX[CW-1:0];
		else if (s < CMIN)
			return CMIN[CW-1:0];
		else
			return s[CW-1:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [FW-1:0] s);
		if (s > OMAX)
			return OMAX[31:0];
		else if (s < OMIN)
			return OMIN[31:0];
		else
			return s[31:0];
	endfunction

	logic signed [31:0]                   coef_q [p2s_pkg::NUM_COEF];
	logic [p2s_pkg::VP_POS_W-1:0]         vp_x_q, vp_y_q;
	logic [p2s_pkg::VP_SIZE_W-1:0]        vp_w_q, vp_h_q;

	logic                                 en, pipe_busy, in_acc;
	logic [p2s_pkg::IDX_W-1:0]            in_idx;
	logic signed [31:0]                   in_coef;
	logic signed [31:0]                   in_pos [3];

	logic                                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [PW-1:0]                 mv_s1 [4][3];
	logic signed [CW-1:0]                 eye_s2 [4];
	logic signed [PW-1:0]                 pj_s3 [3][4];
	logic signed [CW-1:0]                 eye_z_s3;
	logic signed [CW-1:0]                 clip_s4 [3];
	logic signed [CW-1:0]                 eye_z_s4;
	logic signed [NW-1:0]                 ndc [3];
	p2s_pkg::div_stat_t                   dstat;
	logic signed [VW-1:0]                 mx_s5, my_s5;
	logic signed [NW:0]                   sz_s5;
	logic                                 zero_s5;

	logic [p2s_pkg::OUT_DATA_W-1:0]       res_data;
	logic                                 res_valid;
	logic [p2s_pkg::OUT_DATA_W-1:0]       skid_data_q;
	logic                                 skid_user_q, skid_v_q;
	logic [p2s_pkg::OUT_DATA_W-1:0]       out_data_q;
	logic                                 out_user_q, out_v_q;

	// unpack the request
	assign in_idx    = s_axis_tdata[4:0];
	assign in_coef   = s_axis_tdata[36:5];
	assign in_pos[0] = s_axis_tdata[68:37];
	assign in_pos[1] = s_axis_tdata[100:69];
	assign in_pos[2] = s_axis_tdata[132:101];

	// pipeline moves unless the skid stage is holding a result
	assign en        = !skid_v_q;
	assign pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | dstat.busy | v_s5;
	assign s_axis_tready = en && ((s_axis_tuser == p2s_pkg::KIND_PROJECT) || !pipe_busy);
	assign in_acc    = s_axis_tvalid && s_axis_tready;

	// viewport registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_x_q <= '0;
			vp_y_q <= '0;
			vp_w_q <= p2s_pkg::VP_WIDTH_RST;
			vp_h_q <= p2s_pkg::VP_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				p2s_pkg::CFG_VP_X:      vp_x_q <= cfg_data[p2s_pkg::VP_POS_W-1:0];
				p2s_pkg::CFG_VP_Y:      vp_y_q <= cfg_data[p2s_pkg::VP_POS_W-1:0];
				p2s_pkg::CFG_VP_WIDTH:  vp_w_q <= cfg_data;
				p2s_pkg::CFG_VP_HEIGHT: vp_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient store, written by load requests
	always_ff @(posedge clk) begin
		if (in_acc && (s_axis_tuser == p2s_pkg::KIND_LOAD))
			coef_q[in_idx] <= in_coef;
	end

	// valid bits of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc && (s_axis_tuser == p2s_pkg::KIND_PROJECT);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= dstat.valid;
		end
	end

	// stage 1: modelview products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 3; c++)
					mv_s1[r][c] <= PW'(coef_q[4*c + r]) * PW'(in_pos[c]);
		end
	end

	// stage 2: eye coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				eye_s2[r] <= sat_cw(64'(rnd(mv_s1[r][0])) + 64'(rnd(mv_s1[r][1])) +
				                    64'(rnd(mv_s1[r][2])) + 64'(coef_q[12 + r]));
		end
	end

	// stage 3: projection products
	always_ff @(posedge clk) begin
		if (en) begin
			eye_z_s3 <= eye_s2[2];
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 4; c++)
					pj_s3[r][c] <= PW'(coef_q[16 + 4*c + r]) * PW'(eye_s2[c]);
		end
	end

	// stage 4: clip coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			eye_z_s4 <= eye_z_s3;
			for (int r = 0; r < 3; r++)
				clip_s4[r] <= sat_cw(64'(rnd(pj_s3[r][0])) + 64'(rnd(pj_s3[r][1])) +
				                     64'(rnd(pj_s3[r][2])) + 64'(rnd(pj_s3[r][3])));
		end
	end

	// perspective divide
	p2s_div #(
		.FRAC_BITS   (FRAC_BITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (clip_s4),
		.eye_z    (eye_z_s4),
		.ndc      (ndc),
		.stat     (dstat)
	);

	// stage 5: viewport scale products and depth map
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= dstat.zero;
			mx_s5   <= VW'((NW + 1)'(ndc[0]) + ((NW + 1)'(1) <<< F)) *
			           VW'($signed({1'b0, vp_w_q}));
			my_s5   <= VW'((NW + 1)'(ndc[1]) + ((NW + 1)'(1) <<< F)) *
			           VW'($signed({1'b0, vp_h_q}));
			sz_s5   <= ((NW + 1)'(ndc[2]) + ((NW + 1)'(1) <<< F) + (NW + 1)'(1)) >>> 1;
		end
	end

	// final offsets, y flip and saturation
	always_comb begin
		logic signed [FW-1:0] hx, hy, sx, sy;
		hx = (FW'(mx_s5) + FW'(1)) >>> 1;
		hy = (FW'(my_s5) + FW'(1)) >>> 1;
		sx = hx + (FW'($signed({1'b0, vp_x_q})) <<< F);
		sy = (FW'($signed({1'b0, vp_h_q})) <<< F) -
		     (hy + (FW'($signed({1'b0, vp_y_q})) <<< F));
		if (zero_s5)
			res_data = '0;
		else
			res_data = {sat32(FW'(sz_s5)), sat32(sy), sat32(sx)};
		res_valid = v_s5 && en;
	end

	// output register and skid stage, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready)
				skid_v_q <= 1'b0;
		end else if (res_valid) begin
			if (out_v_q && !m_axis_tready)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// output register and skid stage, data
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (res_valid) begin
			if (out_v_q && !m_axis_tready) begin
				skid_data_q <= res_data;
				skid_user_q <= !zero_s5;
			end else begin
				out_data_q <= res_data;
				out_user_q <= !zero_s5;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// a held skid entry always has a result in front of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> m_axis_tvalid)
		else $error("skid stage full with empty output register");

	// a point flagged invalid carries zero coordinates
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("invalid point with nonzero coordinates");

	// with nothing in flight the skid stage cannot fill
	a_idle_no_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(!pipe_busy && !skid_v_q) |=> !skid_v_q)
		else $error("skid stage filled from an empty pipeline");

endmodule

// ===== tb/p2s_checker.sv =====
// result checker for the point to screen projection block: watches the request, result
// and configuration ports, predicts every window point and compares; depends on p2s_pkg
`timescale 1ns / 100ps

module p2s_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [p2s_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [p2s_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [p2s_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [p2s_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                             m_axis_tuser,
	output int                               errors,
	output int                               pending,
	output int                               points_seen,
	output int                               invalid_seen
);

	localparam int FRAC = 16;

	typedef struct {
		logic signed [p2s_pkg::OUT_W-1:0] x;
		logic signed [p2s_pkg::OUT_W-1:0] y;
		logic signed [p2s_pkg::OUT_W-1:0] depth;
		logic                             valid;
	} screen_point_t;

	screen_point_t expected_points[$];
	longint        coef_store[p2s_pkg::NUM_COEF];
	longint        vp_x, vp_y, vp_w, vp_h;

	// product rounded half away from zero, clamped to +-2^60
	function automatic longint fx_mul(longint a, longint b);
		logic              neg;
		longint unsigned   ma, mb;
		logic [127:0]      p;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? longint'(-a) : a;
		mb  = (b < 0) ? longint'(-b) : b;
		p   = {64'd0, ma} * {64'd0, mb};
		p   = (p + (128'd1 << (FRAC - 1))) >> FRAC;
		if (p > (128'd1 << p2s_pkg::PROD_LIM_SHIFT))
			p = 128'd1 << p2s_pkg::PROD_LIM_SHIFT;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	// quotient scaled by 2^FRAC, rounded half away from zero, clamped to +-2^48
	function automatic longint fx_div(longint num, longint den);
		logic              neg;
		longint unsigned   n, d;
		logic [127:0]      q, r;
		neg = (num < 0) != (den < 0);
		n   = (num < 0) ? longint'(-num) : num;
		d   = (den < 0) ? longint'(-den) : den;
		if (d == 0)
			return 0;
		q = ({64'd0, n} << FRAC) / d;
		r = ({64'd0, n} << FRAC) % d;
		if (r >= d - r)
			q++;
		if (q > (128'd1 << p2s_pkg::NDC_LIM_SHIFT))
			q = 128'd1 << p2s_pkg::NDC_LIM_SHIFT;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint sat_bits32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// halving that rounds toward plus infinity
	function automatic longint halve_up(longint v);
		return (v + 1) >>> 1;
	endfunction

	function automatic screen_point_t project_point(longint px, longint py, longint pz);
		screen_point_t res;
		longint        eye[4];
		longint        clip[3];
		longint        ndc[3];
		longint        one, sx, sy, sz;
		for (int r = 0; r < 4; r++)
			eye[r] = sat_bits32(fx_mul(coef_store[r], px) + fx_mul(coef_store[4 + r], py) +
				fx_mul(coef_store[8 + r], pz) + coef_store[12 + r]);
		for (int r = 0; r < 3; r++)
			clip[r] = sat_bits32(fx_mul(coef_store[16 + r], eye[0]) +
				fx_mul(coef_store[20 + r], eye[1]) + fx_mul(coef_store[24 + r], eye[2]) +
				fx_mul(coef_store[28 + r], eye[3]));
		if (eye[2] == 0) begin
			res.x = '0;
			res.y = '0;
			res.depth = '0;
			res.valid = 1'b0;
			return res;
		end
		for (int r = 0; r < 3; r++)
			ndc[r] = fx_div(clip[r], -eye[2]);
		one = 64'sd1 <<< FRAC;
		sx  = halve_up((ndc[0] + one) * vp_w) + (vp_x <<< FRAC);
		sy  = halve_up((ndc[1] + one) * vp_h) + (vp_y <<< FRAC);
		sy  = (vp_h <<< FRAC) - sy;
		sz  = halve_up(ndc[2] + one);
		res.x = sat_bits32(sx);
		res.y = sat_bits32(sy);
		res.depth = sat_bits32(sz);
		res.valid = 1'b1;
		return res;
	endfunction

	// track configuration, requests and results at each edge
	always @(posedge clk or negedge arst_n) begin
		screen_point_t want, got;
		if (!arst_n) begin
			expected_points.delete();
			foreach (coef_store[i])
				coef_store[i] = 0;
			vp_x = 0;
			vp_y = 0;
			vp_w = p2s_pkg::VP_WIDTH_RST;
			vp_h = p2s_pkg::VP_HEIGHT_RST;
			errors = 0;
			pending = 0;
			points_seen = 0;
			invalid_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					p2s_pkg::CFG_VP_X:      vp_x = cfg_data[p2s_pkg::VP_POS_W-1:0];
					p2s_pkg::CFG_VP_Y:      vp_y = cfg_data[p2s_pkg::VP_POS_W-1:0];
					p2s_pkg::CFG_VP_WIDTH:  vp_w = cfg_data[p2s_pkg::VP_SIZE_W-1:0];
					p2s_pkg::CFG_VP_HEIGHT: vp_h = cfg_data[p2s_pkg::VP_SIZE_W-1:0];
					default: ;
				endcase
			end
			// results are compared before a new request of the same edge is predicted
			if (m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[31:0];
				got.y = m_axis_tdata[63:32];
				got.depth = m_axis_tdata[95:64];
				got.valid = m_axis_tuser;
				points_seen++;
				if (!got.valid)
					invalid_seen++;
				if (expected_points.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: x %h y %h depth %h valid %b",
						$time, got.x, got.y, got.depth, got.valid);
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x) begin
						errors++;
						$display("%0t: screen_x expected %h actual %h", $time, want.x, got.x);
					end
					if (got.y !== want.y) begin
						errors++;
						$display("%0t: screen_y expected %h actual %h", $time, want.y, got.y);
					end
					if (got.depth !== want.depth) begin
						errors++;
						$display("%0t: screen_depth expected %h actual %h", $time,
							want.depth, got.depth);
					end
					if (got.valid !== want.valid) begin
						errors++;
						$display("%0t: point_valid expected %b actual %b", $time,
							want.valid, got.valid);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == p2s_pkg::KIND_LOAD)
					coef_store[s_axis_tdata[4:0]] = longint'($signed(s_axis_tdata[36:5]));
				else
					expected_points.push_back(project_point(
						longint'($signed(s_axis_tdata[68:37])),
						longint'($signed(s_axis_tdata[100:69])),
						longint'($signed(s_axis_tdata[132:101]))));
			end
			pending = expected_points.size();
		end
	end

endmodule

// ===== tb/tb_point_to_screen_projection.sv =====
// top of the testbench for point_to_screen_projection: clock, reset, stimulus and verdict
// depends on p2s_pkg, the block and p2s_checker
`timescale 1ns / 100ps

module tb_point_to_screen_projection;

	localparam int SETTLE_CYCLES = 70;
	localparam int STALL_LIMIT   = 5000;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [p2s_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [p2s_pkg::CFG_DATA_W-1:0]   cfg_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [p2s_pkg::IN_DATA_W-1:0]    s_axis_tdata;
	logic                             s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [p2s_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic                             m_axis_tuser;

	int  errors, pending, points_seen, invalid_seen;
	int  requests_sent;
	int  settings_used;
	int  quiet_cycles;
	int  ready_stall;
	int  ready_pick;
	bit  no_idle;

	point_to_screen_projection dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	p2s_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.points_seen   (points_seen),
		.invalid_seen  (invalid_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side back pressure: mostly short stalls, a few long ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_stall <= 0;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else if (ready_stall > 0) begin
			ready_stall <= ready_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 15)
				ready_stall <= $urandom_range(1, 3);
			else if (ready_pick < 18)
				ready_stall <= $urandom_range(10, 50);
		end
	end

	// watchdog on cycles with no handshake on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// small fixed point value in +-2^(bits-1)
	function automatic logic [31:0] near_zero(int bits);
		return 32'($urandom_range(0, (1 << bits) - 1)) - 32'(1 << (bits - 1));
	endfunction

	function automatic logic [31:0] rand_pos();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return near_zero(23);
		if (r < 85)
			return $urandom;
		if (r < 95)
			return near_zero(8);
		return r[0] ? 32'h7fffffff : 32'h80000000;
	endfunction

	task automatic send_request(logic kind, logic [4:0] idx, logic [31:0] coef,
		logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {3'b000, pz, py, px, coef, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic load_coef(int idx, logic [31:0] value);
		send_request(p2s_pkg::KIND_LOAD, 5'(idx), value, $urandom, $urandom, $urandom);
	endtask

	task automatic project(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		send_request(p2s_pkg::KIND_PROJECT, 5'($urandom), $urandom, px, py, pz);
	endtask

	// whole matrix set: 0 tame, 1 full range, 2 perspective with jitter
	task automatic load_matrices(int style);
		logic [31:0] v;
		for (int i = 0; i < p2s_pkg::NUM_COEF; i++) begin
			case (style)
				0: v = (i % 4 == 3 && i < 16 && i != 15) ? near_zero(10) : near_zero(18);
				1: v = $urandom;
				default: begin
					v = near_zero(9);
					if (i == 0 || i == 5 || i == 10 || i == 15 || i == 16 || i == 21)
						v += 32'h00010000;
					if (i == 14)
						v = 32'hfffb0000 + near_zero(16);
					if (i == 26)
						v = 32'hfffecccd;
					if (i == 27)
						v = 32'hffff0000;
					if (i == 30)
						v = 32'hffffcccd;
				end
			endcase
			load_coef(i, v);
		end
	endtask

	// let the pipeline drain before touching configuration
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_viewport(logic [12:0] vx, logic [12:0] vy, logic [12:0] w,
		logic [12:0] h);
		logic [12:0]                   vals[4];
		logic [p2s_pkg::CFG_IDX_W-1:0] regs[4];
		vals = '{vx, vy, w, h};
		regs = '{p2s_pkg::CFG_VP_X, p2s_pkg::CFG_VP_Y, p2s_pkg::CFG_VP_WIDTH,
			p2s_pkg::CFG_VP_HEIGHT};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_phase(int count);
		int r;
		load_matrices($urandom_range(0, 9) < 7 ? 2 : 0);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 1)
				load_matrices($urandom_range(0, 2));
			else if (r < 8)
				load_coef($urandom_range(0, 31), $urandom_range(0, 1) ? near_zero(18) : $urandom);
			else
				project(rand_pos(), rand_pos(), rand_pos());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = p2s_pkg::KIND_LOAD;
		no_idle = 1'b0;
		requests_sent = 0;
		settings_used = 1;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default viewport, standard perspective view
		load_matrices(2);
		project(32'h0, 32'h0, 32'h0);
		project(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		project(32'h80000000, 32'h80000000, 32'h80000000);
		project(32'h00010000, 32'hffff0000, 32'hfffe0000);
		// pz term and offset cancel in eye z, leaving 3*coef 2 + 2*coef 6: a near-zero, possibly invalid point
		load_coef(8, 32'h0);
		load_coef(9, 32'h0);
		load_coef(10, 32'h00010000);
		load_coef(14, 32'hfffb0000);
		project(32'h00030000, 32'h00020000, 32'h00050000);
		// extreme coefficients
		load_coef(0, 32'h7fffffff);
		load_coef(21, 32'h80000000);
		project(32'h00010000, 32'h00010000, 32'h00000000);
		project(32'hffff0000, 32'h00008000, 32'hffff8000);
		wait_drained();

		// random phases across viewport settings, extremes first
		set_viewport(13'd0, 13'd0, 13'd1, 13'd1);
		random_phase(30);
		wait_drained();
		set_viewport(13'd4095, 13'd4095, 13'd4096, 13'd4096);
		no_idle = 1'b1;
		random_phase(30);
		wait_drained();
		no_idle = 1'b0;
		set_viewport(13'h1fff, 13'h1fff, 13'h1fff, 13'h1fff);
		random_phase(25);
		wait_drained();
		set_viewport(13'd17, 13'd300, 13'd0, 13'd0);
		random_phase(20);
		wait_drained();
		for (int p = 0; p < 3; p++) begin
			set_viewport(13'($urandom), 13'($urandom), 13'($urandom_range(1, 4096)),
				13'($urandom_range(1, 4096)));
			random_phase(30);
			wait_drained();
		end

		$display("sent %0d requests over %0d viewport settings", requests_sent, settings_used);
		$display("checked %0d window points, %0d of them flagged invalid", points_seen,
			invalid_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
src/p2s_pkg.sv
src/p2s_div.sv
src/point_to_screen_projection.sv
tb/p2s_checker.sv
tb/tb_point_to_screen_projection.sv
